>>> src/des_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg
// tables, stage payload type and permutation helpers for the des pipeline
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int NumRounds = 16;

  // payload carried from one round cell to the next
  typedef struct packed {
    logic        dec;
    logic [31:0] l;
    logic [31:0] r;
    logic [55:0] cd;
  } des_stage_t;

  localparam logic [6:0] IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [6:0] FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [5:0] E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [5:0] P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

  localparam logic [6:0] PC1_TAB [56] = '{
    57,49,41,33,25,17,9,1, 58,50,42,34,26,18,10,2,
    59,51,43,35,27,19,11,3, 60,52,44,36,63,55,47,39,
    31,23,15,7,62,54,46,38, 30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};

  localparam logic [5:0] PC2_TAB [48] = '{
    14,17,11,24,1,5,3,28, 15,6,21,10,23,19,12,4,
    26,8,16,7,27,20,13,2, 41,52,31,37,47,55,30,40,
    51,45,33,48,44,49,39,56, 34,53,46,42,50,36,29,32};

  localparam logic [1:0] ROT_TAB [NumRounds] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  // s-boxes, entry [row * 16 + column]
  localparam logic [3:0] SBOX_TAB [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // table entry n names standard bit n, which is vector bit (width - n)
  function automatic logic [63:0] perm_ip(input logic [63:0] din);
    logic [63:0] dout;
    for (int i = 0; i < 64; i++) dout[63 - i] = din[64 - int'(IP_TAB[i])];
    return dout;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] din);
    logic [63:0] dout;
    for (int i = 0; i < 64; i++) dout[63 - i] = din[64 - int'(FP_TAB[i])];
    return dout;
  endfunction

  function automatic logic [47:0] perm_e(input logic [31:0] din);
    logic [47:0] dout;
    for (int i = 0; i < 48; i++) dout[47 - i] = din[32 - int'(E_TAB[i])];
    return dout;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] din);
    logic [31:0] dout;
    for (int i = 0; i < 32; i++) dout[31 - i] = din[32 - int'(P_TAB[i])];
    return dout;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] din);
    logic [55:0] dout;
    for (int i = 0; i < 56; i++) dout[55 - i] = din[64 - int'(PC1_TAB[i])];
    return dout;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] din);
    logic [47:0] dout;
    for (int i = 0; i < 48; i++) dout[47 - i] = din[56 - int'(PC2_TAB[i])];
    return dout;
  endfunction

  // eight s-box lookups, outer bits pick the row
  function automatic logic [31:0] sbox_all(input logic [47:0] din);
    logic [31:0] dout;
    logic [5:0]  six;
    for (int j = 0; j < 8; j++) begin
      six = din[47 - 6 * j -: 6];
      dout[31 - 4 * j -: 4] = SBOX_TAB[j][{six[5], six[0], six[4:1]}];
    end
    return dout;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] n);
    return (n == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
  endfunction

  function automatic logic [27:0] rotr28(input logic [27:0] v, input logic [1:0] n);
    return (n == 2'd2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
  endfunction

endpackage

>>> src/des_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_round_cell
// one feistel round with its own key schedule step, registered output
// ----------------------------------------------------------------------------
module des_round_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          stage,
  input  logic                in_vld,
  output logic                in_rdy,
  input  des_pkg::des_stage_t in_data,
  output logic                out_vld,
  input  logic                out_rdy,
  output des_pkg::des_stage_t out_data
);
  import des_pkg::*;

  logic [1:0]  rot;
  logic [55:0] cd_enc;
  logic [55:0] cd_dec;
  logic [47:0] subkey;
  logic [31:0] f_out;
  des_stage_t  data_next;

  always_comb begin
    // decryption walks the schedule backwards
    rot    = in_data.dec ? ROT_TAB[4'd15 - stage] : ROT_TAB[stage];
    cd_enc = {rotl28(in_data.cd[55:28], rot), rotl28(in_data.cd[27:0], rot)};
    cd_dec = {rotr28(in_data.cd[55:28], rot), rotr28(in_data.cd[27:0], rot)};
    subkey = perm_pc2(in_data.dec ? in_data.cd : cd_enc);
    f_out  = perm_p(sbox_all(perm_e(in_data.r) ^ subkey));

    data_next.dec = in_data.dec;
    data_next.l   = in_data.r;
    data_next.r   = in_data.l ^ f_out;
    data_next.cd  = in_data.dec ? cd_dec : cd_enc;
  end

  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      out_data <= data_next;
    end
  end

endmodule

>>> src/des_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_block_cipher
// fully pipelined single-block des, one round cell per round
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    req_type, block_in
// output    out        out_valid / out_ready  block_out
// key       in         cfg_we                 cipher_key
//
// one transaction accepted per cycle while out_ready back-pressure has not filled the chain,
// each passing 16 round cells plus the output register, the first cell loads on the accepting edge
// each cell stalls only when it is full and its downstream is full, so
// bubbles collapse and a stalled output still lets the chain fill up
// rst is synchronous and clears the valid bits and the key to zero
// the key feeds the first cell through pc-1, the block does not enforce it, so the user writes it only while idle
// ----------------------------------------------------------------------------
module des_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cipher_key,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [63:0] block_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] block_out
);
  import des_pkg::*;

  logic [63:0] key;
  logic [63:0] ip_blk;

  // chain links: index n feeds cell n, index NumRounds feeds the output register
  logic       vld  [NumRounds + 1];
  logic       rdy  [NumRounds + 1];
  des_stage_t data [NumRounds + 1];

  // key register
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      key <= cipher_key;
    end
  end

  // entry: initial permutation of the block and pc-1 of the key
  assign ip_blk      = perm_ip(block_in);
  assign vld[0]      = in_valid;
  assign in_ready    = rdy[0];
  assign data[0].dec = req_type;
  assign data[0].l   = ip_blk[63:32];
  assign data[0].r   = ip_blk[31:0];
  assign data[0].cd  = perm_pc1(key);

  for (genvar i = 0; i < NumRounds; i++) begin : g_round
    des_round_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (4'(i)),
      .in_vld   (vld[i]),
      .in_rdy   (rdy[i]),
      .in_data  (data[i]),
      .out_vld  (vld[i + 1]),
      .out_rdy  (rdy[i + 1]),
      .out_data (data[i + 1])
    );
  end

  // output register: halves swap after the last round, then the final permutation
  assign rdy[NumRounds] = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[NumRounds]) begin
      out_valid <= vld[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (vld[NumRounds] && rdy[NumRounds]) begin
      block_out <= perm_fp({data[NumRounds].r, data[NumRounds].l});
    end
  end

endmodule

>>> sim/des_block_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_block_cipher_test
// self-checking bench for the pipelined des block: known-answer and random
// blocks under several keys, both directions, with random stalls on either
// side, every result checked in order against a known answer or a local des computation
// ----------------------------------------------------------------------------
module des_block_cipher_test;

  // operation selector on req_type
  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  // which bit-selection table a permutation uses
  typedef enum int {
    MAP_IP,
    MAP_FP,
    MAP_E,
    MAP_P,
    MAP_PC1,
    MAP_PC2
  } bitmap_e;

  // one row of the directed stimulus; want is only used when known is set
  typedef struct packed {
    logic        wr_key;
    logic [63:0] key;
    op_e         op;
    logic [63:0] text;
    logic        known;
    logic [63:0] want;
  } probe_t;

  localparam int RandPhases  = 10;
  localparam int PhaseBlocks = 125;
  localparam int IdlePct     = 7;
  localparam int TailCycles  = 40;   // pipeline depth is 17, plus margin

  // entry i of a map names the source bit (1 = msb) of output bit i
  localparam int BitMap [6][64] = '{
    '{58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7},
    '{40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25},
    '{32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
      28,29,30,31,32,1, 0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25,
      0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0},
    '{57,49,41,33,25,17,9,1, 58,50,42,34,26,18,10,2,
      59,51,43,35,27,19,11,3, 60,52,44,36,63,55,47,39,
      31,23,15,7,62,54,46,38, 30,22,14,6,61,53,45,37,
      29,21,13,5,28,20,12,4, 0,0,0,0,0,0,0,0},
    '{14,17,11,24,1,5,3,28, 15,6,21,10,23,19,12,4,
      26,8,16,7,27,20,13,2, 41,52,31,37,47,55,30,40,
      51,45,33,48,44,49,39,56, 34,53,46,42,50,36,29,32,
      0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0}};

  // left rotation of the key halves before each round
  localparam int ShiftSched [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  // s-boxes, one 64-bit word per row, column 0 in the top nibble
  localparam logic [63:0] SboxRows [8][4] = '{
    '{64'he4d12fb83a6c5907, 64'h0f74e2d1a6cb9538,
      64'h41e8d62bfc973a50, 64'hfc8249175b3ea06d},
    '{64'hf18e6b34972dc05a, 64'h3d47f28ec01a69b5,
      64'h0e7ba4d158c6932f, 64'hd8a13f42b67c05e9},
    '{64'ha09e63f51dc7b428, 64'hd709346a285ecbf1,
      64'hd6498f30b12c5ae7, 64'h1ad069874fe3b52c},
    '{64'h7de3069a1285bc4f, 64'hd8b56f03472c1ae9,
      64'ha690cb7df13e5284, 64'h3f06a1d8945bc72e},
    '{64'h2c417ab6853fd0e9, 64'heb2c47d150fa3986,
      64'h421bad78f9c5630e, 64'hb8c71e2d6f09a453},
    '{64'hc1af92680d34e75b, 64'haf427c9561de0b38,
      64'h9ef528c3704a1db6, 64'h432c95fabe17608d},
    '{64'h4b2ef08d3c975a61, 64'hd0b7491ae35c2f86,
      64'h14bdc37eaf680592, 64'h6bd814a7950fe23c},
    '{64'hd2846fb1a93e50c7, 64'h1fd8a374c56b0e92,
      64'h7b419ce206adf358, 64'h21e74a8dfc90356b}};

  // directed rows: reset key, extreme keys and blocks, published vectors,
  // a key that differs only in parity bits, a weak and a semi-weak key
  localparam probe_t Probes [18] = '{
    '{1'b0, 64'h0, OP_ENCRYPT, 64'h0000000000000000, 1'b1, 64'h8ca64de9c1b123a7},
    '{1'b0, 64'h0, OP_DECRYPT, 64'h8ca64de9c1b123a7, 1'b1, 64'h0000000000000000},
    '{1'b0, 64'h0, OP_ENCRYPT, 64'hffffffffffffffff, 1'b0, 64'h0},
    '{1'b0, 64'h0, OP_DECRYPT, 64'h8000000000000001, 1'b0, 64'h0},
    '{1'b1, 64'hffffffffffffffff, OP_ENCRYPT, 64'hffffffffffffffff,
      1'b1, 64'h7359b2163e4edc58},
    '{1'b0, 64'hffffffffffffffff, OP_DECRYPT, 64'h7359b2163e4edc58,
      1'b1, 64'hffffffffffffffff},
    '{1'b0, 64'hffffffffffffffff, OP_ENCRYPT, 64'h0000000000000000, 1'b0, 64'h0},
    '{1'b1, 64'h133457799bbcdff1, OP_ENCRYPT, 64'h0123456789abcdef,
      1'b1, 64'h85e813540f0ab405},
    '{1'b0, 64'h133457799bbcdff1, OP_DECRYPT, 64'h85e813540f0ab405,
      1'b1, 64'h0123456789abcdef},
    '{1'b1, 64'h123556789abddef0, OP_ENCRYPT, 64'h0123456789abcdef,
      1'b1, 64'h85e813540f0ab405},
    '{1'b1, 64'h0e329232ea6d0d73, OP_ENCRYPT, 64'h8787878787878787,
      1'b1, 64'h0000000000000000},
    '{1'b0, 64'h0e329232ea6d0d73, OP_DECRYPT, 64'h0000000000000000,
      1'b1, 64'h8787878787878787},
    '{1'b1, 64'h0101010101010101, OP_ENCRYPT, 64'h0123456789abcdef, 1'b0, 64'h0},
    '{1'b0, 64'h0101010101010101, OP_DECRYPT, 64'h0123456789abcdef, 1'b0, 64'h0},
    '{1'b1, 64'h01fe01fe01fe01fe, OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0},
    '{1'b0, 64'h01fe01fe01fe01fe, OP_DECRYPT, 64'h5555555555555555, 1'b0, 64'h0},
    '{1'b1, 64'h0000000000000000, OP_ENCRYPT, 64'h8000000000000000, 1'b0, 64'h0},
    '{1'b0, 64'h0000000000000000, OP_DECRYPT, 64'h0000000000000001, 1'b0, 64'h0}};

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cipher_key;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [63:0] block_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] block_out;

  logic [63:0] key_now;        // key the block holds right now
  logic [63:0] block_expect_q [$];
  logic [63:0] last_block;     // most recent expected result
  logic [63:0] got_want;
  logic        calm;           // no idling on either side while set
  int          fail_count = 0;
  int          enc_count;
  int          dec_count;
  int          key_loads;

  des_block_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cipher_key(cipher_key),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .block_in  (block_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .block_out (block_out)
  );

  always #1 clk = ~clk;

  // gather n bits of src (width src_w) in the order a table gives
  function automatic logic [63:0] pick_bits(input logic [63:0] src, input int src_w,
                                            input bitmap_e m, input int n);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < n; i++) res = {res[62:0], src[src_w - BitMap[m][i]]};
    return res;
  endfunction

  // full des on one block: key schedule, initial permutation, 16 rounds, final permutation
  function automatic logic [63:0] des_transform(input logic [63:0] key, input op_e op,
                                                input logic [63:0] text);
    logic [47:0] subkey [16];
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [63:0] perm;
    logic [31:0] lh, rh, keep, sbo;
    logic [47:0] ex;
    logic [5:0]  six;
    cd = 56'(pick_bits(key, 64, MAP_PC1, 56));
    c  = cd[55:28];
    d  = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      for (int s = 0; s < ShiftSched[i]; s++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      subkey[i] = 48'(pick_bits({8'h00, c, d}, 56, MAP_PC2, 48));
    end
    perm = pick_bits(text, 64, MAP_IP, 64);
    lh   = perm[63:32];
    rh   = perm[31:0];
    sbo  = '0;
    for (int i = 0; i < 16; i++) begin
      // decryption walks the same subkeys backwards
      ex = 48'(pick_bits({32'h0, rh}, 32, MAP_E, 48)) ^
           subkey[(op == OP_DECRYPT) ? 15 - i : i];
      for (int j = 0; j < 8; j++) begin
        six = ex[47 - 6 * j -: 6];
        // outer bits pick the row, inner four the column
        sbo = {sbo[27:0],
               4'(SboxRows[j][{six[5], six[0]}] >> (60 - 4 * int'(six[4:1])))};
      end
      keep = rh;
      rh   = lh ^ 32'(pick_bits({32'h0, sbo}, 32, MAP_P, 32));
      lh   = keep;
    end
    // halves swap before the final permutation
    return pick_bits({rh, lh}, 64, MAP_FP, 64);
  endfunction

  // offer one block; idle gaps come first, then valid holds until accepted
  task automatic push_block(input op_e op, input logic [63:0] text,
                            input logic known, input logic [63:0] want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = op;
    block_in = text;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transaction taken on this edge
    last_block = known ? want : des_transform(key_now, op, text);
    block_expect_q.push_back(last_block);
    if (op == OP_DECRYPT) dec_count++;
    else enc_count++;
  endtask

  // stop sending and wait until every pending result has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (block_expect_q.size() != 0) @(posedge clk);
  endtask

  // single-cycle key write, only ever issued with the pipeline empty
  task automatic load_key(input logic [63:0] k);
    @(negedge clk);
    cfg_we     = 1'b1;
    cipher_key = k;
    @(negedge clk);
    cfg_we  = 1'b0;
    key_now = k;
    key_loads++;
  endtask

  // receiver: random back-pressure, decided at the falling edge
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // result checker: every output transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (block_expect_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected result block_out=%h", block_out);
        fail_count++;
      end else begin
        got_want = block_expect_q.pop_front();
        if (block_out !== got_want) begin
          if (fail_count < 10) begin
            $display("block_out mismatch: expected %h, got %h", got_want, block_out);
          end
          fail_count++;
        end
      end
    end
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #400000;
    $display("[des_block_cipher] ERROR");
    $finish;
  end

  initial begin
    logic [63:0] k;
    logic [63:0] text;
    int          pick;
    int          target;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cipher_key = '0;
    in_valid   = 1'b0;
    req_type   = OP_ENCRYPT;
    block_in   = '0;
    key_now    = '0;
    last_block = '0;
    calm       = 1'b0;
    enc_count  = 0;
    dec_count  = 0;
    key_loads  = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed rows, first ones run on the key left by reset
    for (int n = 0; n < $size(Probes); n++) begin
      if (Probes[n].wr_key) begin
        drain();
        load_key(Probes[n].key);
      end
      push_block(Probes[n].op, Probes[n].text, Probes[n].known, Probes[n].want);
    end

    // random phases, each with its own key written while the pipe is empty
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain();
      case (ph)
        0: k = 64'hffffffffffffffff;
        1: k = 64'h0000000000000000;
        2: k = 64'hfefefefefefefefe;                // weak key
        9: k = key_now ^ 64'h0101010101010101;      // parity bits only
        default: k = {$urandom, $urandom};
      endcase
      load_key(k);
      calm   = (ph == 4);   // one long back-to-back stretch
      target = enc_count + dec_count + PhaseBlocks;
      while (enc_count + dec_count < target) begin
        pick = $urandom_range(9);
        text = {$urandom, $urandom};
        if (pick < 4) begin
          // round trip: encrypt, then decrypt what came out
          push_block(OP_ENCRYPT, text, 1'b0, 64'h0);
          push_block(OP_DECRYPT, last_block, 1'b0, 64'h0);
        end else if (pick < 7) begin
          push_block(OP_ENCRYPT, text, 1'b0, 64'h0);
        end else begin
          push_block(OP_DECRYPT, text, 1'b0, 64'h0);
        end
      end
      calm = 1'b0;
    end

    drain();
    repeat (TailCycles) @(posedge clk);

    $display("ran %0d encrypt and %0d decrypt blocks across %0d key loads",
             enc_count, dec_count, key_loads);
    $display("keys included all-zero, all-one, weak, semi-weak and parity-flipped");
    if (fail_count == 0) begin
      $display("[des_block_cipher] OK");
    end else begin
      $display("%0d failing results", fail_count);
      $display("[des_block_cipher] ERROR");
    end
    $finish;
  end

endmodule
